>>> rtl/core/cjs_pkg.sv
// Shared types and constants of the job scheduler.
`timescale 1ns / 1ps
`default_nettype none
package cjs_pkg;

  localparam int unsigned REQ_W      = 1;
  localparam int unsigned ID_W       = 8;
  localparam int unsigned SVC_W      = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned OUT_TIME_W = 16;
  localparam int unsigned POLICY_W   = 2;
  localparam int unsigned QUANTUM_W  = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [REQ_W-1:0] REQ_ARRIVAL = 1'b0;
  localparam logic [REQ_W-1:0] REQ_TICK    = 1'b1;

  localparam logic [POLICY_W-1:0] POL_FCFS = 2'd0;
  localparam logic [POLICY_W-1:0] POL_SJF  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_HRRN = 2'd2;
  localparam logic [POLICY_W-1:0] POL_RR   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DROPPED   = 3'd1,
    ST_IDLE_TICK = 3'd2,
    ST_RUN_TICK  = 3'd3,
    ST_DONE      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ARRIVE,
    S_DISP_CHK,
    S_SCAN_RD,
    S_SCAN_MUL,
    S_SCAN_CMP,
    S_SHIFT_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_APPEND,
    S_COMMIT,
    S_RUN
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic arrive;
    logic scan_start;
    logic scan_mul;
    logic scan_cmp;
    logic shift_rd;
    logic shift_wr;
    logic append;
    logic commit;
    logic run;
  } cmd_t;

  typedef struct packed {
    logic in_is_tick;
    logic need_dispatch;
    logic scan_last;
    logic best_in_queue;
    logic shift_more;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/cjs_in_if.sv
// Input channel of the job scheduler: arrivals and ticks.
`timescale 1ns / 1ps
`default_nettype none
interface cjs_in_if;
  logic                        valid;
  logic                        ready;
  logic [cjs_pkg::REQ_W-1:0]   req_type;
  logic [cjs_pkg::ID_W-1:0]    job_id;
  logic [cjs_pkg::SVC_W-1:0]   service_time;

  modport source (output valid, req_type, job_id, service_time, input ready);
  modport sink   (input valid, req_type, job_id, service_time, output ready);
endinterface
`default_nettype wire

>>> rtl/core/cjs_out_if.sv
// Result channel of the job scheduler.
`timescale 1ns / 1ps
`default_nettype none
interface cjs_out_if;
  logic                             valid;
  logic                             ready;
  logic [cjs_pkg::STATUS_W-1:0]     status;
  logic [cjs_pkg::ID_W-1:0]         job_id_out;
  logic [cjs_pkg::OUT_TIME_W-1:0]   arrival_stamp;
  logic [cjs_pkg::OUT_TIME_W-1:0]   finish_time;
  logic [cjs_pkg::OUT_TIME_W-1:0]   turnaround;
  logic [cjs_pkg::OUT_TIME_W-1:0]   waiting_time;
  logic [cjs_pkg::OUT_TIME_W-1:0]   first_start;

  modport source (output valid, status, job_id_out, arrival_stamp, finish_time,
                  turnaround, waiting_time, first_start, input ready);
  modport sink   (input valid, status, job_id_out, arrival_stamp, finish_time,
                  turnaround, waiting_time, first_start, output ready);
endinterface
`default_nettype wire

>>> rtl/core/cjs_ctrl.sv
// Sequencer of the job scheduler: arrival, dispatch scan, queue compaction, tick.
`timescale 1ns / 1ps
`default_nettype none
module cjs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cjs_pkg::sts_t   sts,
  output cjs_pkg::cmd_t   cmd
);

  cjs_pkg::state_t state_r;
  cjs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cjs_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cjs_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_is_tick ? cjs_pkg::S_DISP_CHK : cjs_pkg::S_ARRIVE;
        end
      end
      cjs_pkg::S_ARRIVE: begin
        if (sts.out_free) state_nxt = cjs_pkg::S_IDLE;
      end
      cjs_pkg::S_DISP_CHK: begin
        state_nxt = sts.need_dispatch ? cjs_pkg::S_SCAN_RD : cjs_pkg::S_RUN;
      end
      cjs_pkg::S_SCAN_RD:  state_nxt = cjs_pkg::S_SCAN_MUL;
      cjs_pkg::S_SCAN_MUL: state_nxt = cjs_pkg::S_SCAN_CMP;
      cjs_pkg::S_SCAN_CMP: begin
        state_nxt = sts.scan_last ? cjs_pkg::S_SHIFT_CHK : cjs_pkg::S_SCAN_RD;
      end
      cjs_pkg::S_SHIFT_CHK: begin
        priority if (!sts.best_in_queue) state_nxt = cjs_pkg::S_COMMIT;
        else if (sts.shift_more)         state_nxt = cjs_pkg::S_SHIFT_RD;
        else                             state_nxt = cjs_pkg::S_APPEND;
      end
      cjs_pkg::S_SHIFT_RD: state_nxt = cjs_pkg::S_SHIFT_WR;
      cjs_pkg::S_SHIFT_WR: state_nxt = cjs_pkg::S_SHIFT_CHK;
      cjs_pkg::S_APPEND:   state_nxt = cjs_pkg::S_COMMIT;
      cjs_pkg::S_COMMIT:   state_nxt = cjs_pkg::S_RUN;
      cjs_pkg::S_RUN: begin
        if (sts.out_free) state_nxt = cjs_pkg::S_IDLE;
      end
      default: state_nxt = cjs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      cjs_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      cjs_pkg::S_ARRIVE:    cmd.arrive     = sts.out_free;
      cjs_pkg::S_DISP_CHK:  cmd.scan_start = sts.need_dispatch;
      cjs_pkg::S_SCAN_RD:   ;
      cjs_pkg::S_SCAN_MUL:  cmd.scan_mul   = 1'b1;
      cjs_pkg::S_SCAN_CMP:  cmd.scan_cmp   = 1'b1;
      cjs_pkg::S_SHIFT_CHK: ;
      cjs_pkg::S_SHIFT_RD:  cmd.shift_rd   = 1'b1;
      cjs_pkg::S_SHIFT_WR:  cmd.shift_wr   = 1'b1;
      cjs_pkg::S_APPEND:    cmd.append     = 1'b1;
      cjs_pkg::S_COMMIT:    cmd.commit     = 1'b1;
      cjs_pkg::S_RUN:       cmd.run        = sts.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/cjs_datapath.sv
// Ready queue memory, running job, time counter, dispatch compare and result register.
`timescale 1ns / 1ps
`default_nettype none
module cjs_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cjs_pkg::cmd_t                       cmd,
  output cjs_pkg::sts_t                       sts,
  input  logic [cjs_pkg::REQ_W-1:0]           in_req_type,
  input  logic [cjs_pkg::ID_W-1:0]            in_job_id,
  input  logic [cjs_pkg::SVC_W-1:0]           in_service_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cjs_pkg::STATUS_W-1:0]        out_status,
  output logic [cjs_pkg::ID_W-1:0]            out_job_id,
  output logic [cjs_pkg::OUT_TIME_W-1:0]      out_arrival,
  output logic [cjs_pkg::OUT_TIME_W-1:0]      out_finish,
  output logic [cjs_pkg::OUT_TIME_W-1:0]      out_turnaround,
  output logic [cjs_pkg::OUT_TIME_W-1:0]      out_waiting,
  output logic [cjs_pkg::OUT_TIME_W-1:0]      out_first,
  input  logic                                cfg_we,
  input  logic [cjs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cjs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int unsigned AW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned XW     = CW + 1;
  localparam int unsigned TB     = TIME_BITS;
  localparam int unsigned NUM_W  = TIME_BITS + 1;
  localparam int unsigned SVC_W  = cjs_pkg::SVC_W;
  localparam int unsigned ID_W   = cjs_pkg::ID_W;
  localparam int unsigned PROD_W = NUM_W + SVC_W;
  localparam int unsigned OW     = cjs_pkg::OUT_TIME_W;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SVC_W-1:0] svc;
    logic [SVC_W-1:0] used;
    logic [TB-1:0]    arr;
    logic [TB-1:0]    first;
    logic             started;
  } entry_t;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;
  entry_t run_r;
  entry_t best_r;
  entry_t cand_r;

  logic [CW-1:0]                    count_r;
  logic [TB-1:0]                    time_r;
  logic                             run_valid_r;
  logic [cjs_pkg::QUANTUM_W-1:0]    slice_r;
  logic                             held_r;
  logic [cjs_pkg::POLICY_W-1:0]     policy_r;
  logic [cjs_pkg::QUANTUM_W-1:0]    quantum_r;
  logic [ID_W-1:0]                  req_id_r;
  logic [SVC_W-1:0]                 req_svc_r;
  logic [CW-1:0]                    idx_r;
  logic [CW-1:0]                    best_idx_r;
  logic [CW-1:0]                    shift_j_r;
  logic [PROD_W-1:0]                p_cand_r;
  logic [PROD_W-1:0]                p_best_r;
  logic                             out_valid_r;
  logic [cjs_pkg::STATUS_W-1:0]     status_r;
  logic [ID_W-1:0]                  job_id_r;
  logic [OW-1:0]                    arrival_r;
  logic [OW-1:0]                    finish_r;
  logic [OW-1:0]                    turn_r;
  logic [OW-1:0]                    wait_r;
  logic [OW-1:0]                    first_r;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [AW-1:0]    mem_raddr;
  entry_t           mem_wdata;
  entry_t           new_entry;
  entry_t           commit_entry;
  entry_t           cand;
  logic             has_room;
  logic [CW-1:0]    count_m1;
  logic [CW-1:0]    shift_nx;
  logic [TB-1:0]    cand_age;
  logic [TB-1:0]    best_age;
  logic [NUM_W-1:0] cand_num;
  logic [NUM_W-1:0] best_num;
  logic             beats;
  logic             take;
  logic [TB-1:0]    time_inc;
  logic [SVC_W-1:0] used_inc;
  logic [cjs_pkg::QUANTUM_W-1:0] slice_inc;
  logic             done;
  logic [TB-1:0]    turn;
  logic [TB-1:0]    wait_t;

  assign has_room = count_r < CW'(QUEUE_DEPTH);
  assign count_m1 = count_r - CW'(1);
  assign shift_nx = shift_j_r + CW'(1);

  always_comb begin
    new_entry         = run_r;
    new_entry.id      = req_id_r;
    new_entry.svc     = req_svc_r;
    new_entry.used    = '0;
    new_entry.arr     = time_r;
    new_entry.first   = '0;
    new_entry.started = 1'b0;
  end

  // stamp the first dispatch time once
  always_comb begin
    commit_entry = best_r;
    if (!best_r.started) begin
      commit_entry.started = 1'b1;
      commit_entry.first   = time_r;
    end
  end

  // queue memory: one write and one registered read per cycle
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[AW-1:0];
    mem_wdata = new_entry;
    priority if (cmd.arrive && has_room) begin
      mem_we = 1'b1;
    end else if (cmd.shift_wr) begin
      mem_we    = 1'b1;
      mem_waddr = shift_j_r[AW-1:0];
      mem_wdata = rd_data_r;
    end else if (cmd.append && held_r) begin
      // preempted job rejoins at the tail
      mem_we    = 1'b1;
      mem_waddr = count_m1[AW-1:0];
      mem_wdata = run_r;
    end else begin
      mem_we = 1'b0;
    end
  end

  assign mem_raddr = cmd.shift_rd ? shift_nx[AW-1:0] : idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // dispatch compare
  assign cand     = (idx_r < count_r) ? rd_data_r : run_r;
  assign cand_age = time_r - cand.arr;
  assign best_age = time_r - best_r.arr;
  assign cand_num = NUM_W'(cand_age) + NUM_W'(cand.svc);
  assign best_num = NUM_W'(best_age) + NUM_W'(best_r.svc);

  always_comb begin
    unique case (policy_r)
      cjs_pkg::POL_SJF:  beats = cand_r.svc < best_r.svc;
      cjs_pkg::POL_HRRN: beats = p_cand_r > p_best_r;
      default:           beats = 1'b0;
    endcase
  end

  assign take = (idx_r == '0) || beats;

  // tick arithmetic
  assign time_inc  = time_r + TB'(1);
  assign used_inc  = run_r.used + SVC_W'(1);
  assign slice_inc = (slice_r == '1) ? slice_r : slice_r + cjs_pkg::QUANTUM_W'(1);
  assign done      = used_inc >= run_r.svc;
  assign turn      = time_inc - run_r.arr;
  assign wait_t    = turn - TB'(run_r.svc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r  <= cjs_pkg::POL_FCFS;
      quantum_r <= cjs_pkg::QUANTUM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        cjs_pkg::CFG_POLICY:  policy_r  <= cfg_wdata[cjs_pkg::POLICY_W-1:0];
        cjs_pkg::CFG_QUANTUM: quantum_r <= cfg_wdata[cjs_pkg::QUANTUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      time_r      <= '0;
      run_valid_r <= 1'b0;
      slice_r     <= '0;
      held_r      <= 1'b0;
    end else begin
      if (cmd.arrive && has_room) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.commit) begin
        if (best_idx_r < count_r && !held_r) count_r <= count_m1;
        held_r      <= 1'b0;
        run_valid_r <= 1'b1;
        slice_r     <= '0;
      end
      if (cmd.run) begin
        time_r <= time_inc;
        if (run_valid_r) begin
          slice_r <= slice_inc;
          if (done) begin
            run_valid_r <= 1'b0;
          end else if (policy_r == cjs_pkg::POL_RR && slice_inc >= quantum_r) begin
            held_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_id_r  <= in_job_id;
      req_svc_r <= in_service_time;
    end
    if (cmd.scan_start) begin
      idx_r <= '0;
    end
    if (cmd.scan_mul) begin
      cand_r   <= cand;
      p_cand_r <= PROD_W'(cand_num) * PROD_W'(best_r.svc);
      p_best_r <= PROD_W'(best_num) * PROD_W'(cand.svc);
    end
    if (cmd.scan_cmp) begin
      idx_r <= idx_r + CW'(1);
      if (take) begin
        best_r     <= cand_r;
        best_idx_r <= idx_r;
        shift_j_r  <= idx_r;
      end
    end
    if (cmd.shift_wr) begin
      shift_j_r <= shift_nx;
    end
    if (cmd.commit) begin
      run_r <= commit_entry;
    end
    if (cmd.run && run_valid_r) begin
      run_r.used <= used_inc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.arrive || cmd.run) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arrive) begin
      status_r  <= has_room ? cjs_pkg::ST_ACCEPTED : cjs_pkg::ST_DROPPED;
      job_id_r  <= req_id_r;
      arrival_r <= '0;
      finish_r  <= '0;
      turn_r    <= '0;
      wait_r    <= '0;
      first_r   <= '0;
    end else if (cmd.run) begin
      if (run_valid_r && done) begin
        status_r  <= cjs_pkg::ST_DONE;
        job_id_r  <= run_r.id;
        arrival_r <= OW'(run_r.arr);
        finish_r  <= OW'(time_inc);
        turn_r    <= OW'(turn);
        wait_r    <= OW'(wait_t);
        first_r   <= OW'(run_r.first);
      end else begin
        status_r  <= run_valid_r ? cjs_pkg::ST_RUN_TICK : cjs_pkg::ST_IDLE_TICK;
        job_id_r  <= run_valid_r ? run_r.id : '0;
        arrival_r <= '0;
        finish_r  <= '0;
        turn_r    <= '0;
        wait_r    <= '0;
        first_r   <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_job_id     = job_id_r;
  assign out_arrival    = arrival_r;
  assign out_finish     = finish_r;
  assign out_turnaround = turn_r;
  assign out_waiting    = wait_r;
  assign out_first      = first_r;

  always_comb begin
    sts.in_is_tick    = in_req_type == cjs_pkg::REQ_TICK;
    sts.need_dispatch = held_r || (!run_valid_r && count_r != '0);
    sts.scan_last     = (XW'(idx_r) + XW'(1)) == (XW'(count_r) + XW'(held_r));
    sts.best_in_queue = best_idx_r < count_r;
    sts.shift_more    = (XW'(shift_j_r) + XW'(1)) < XW'(count_r);
    sts.out_free      = !out_valid_r || out_ready;
  end

endmodule
`default_nettype wire

>>> rtl/core/cpu_job_scheduler_fcfs_sjf_rr_hrrn.sv
// Top level of the job scheduler: sequencer plus datapath.
// An arrival passes through ARRIVE, a tick through DISP_CHK and RUN; ARRIVE and RUN wait
// for a free output register. A tick that dispatches also scans the candidates (read,
// multiply, compare for each, through the single queue read port and the response-ratio
// multipliers), moves entries up to close the gap, passes APPEND when the winner leaves
// the queue, and COMMIT. One item is in work at a time; a result waits in the output
// register. Synchronous reset empties the queue, idles the CPU and zeroes time.
`timescale 1ns / 1ps
`default_nettype none
module cpu_job_scheduler_fcfs_sjf_rr_hrrn #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TIME_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  cjs_in_if.sink                            in_ch,
  cjs_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [cjs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cjs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  cjs_pkg::cmd_t cmd;
  cjs_pkg::sts_t sts;
  logic          in_ready;

  cjs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cjs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_ch.req_type),
    .in_job_id       (in_ch.job_id),
    .in_service_time (in_ch.service_time),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_job_id      (out_ch.job_id_out),
    .out_arrival     (out_ch.arrival_stamp),
    .out_finish      (out_ch.finish_time),
    .out_turnaround  (out_ch.turnaround),
    .out_waiting     (out_ch.waiting_time),
    .out_first       (out_ch.first_start),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire

>>> rtl/core/cjs_checker.sv
// Port-level checks of the job scheduler, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cjs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [cjs_pkg::STATUS_W-1:0]      out_status,
  input logic [cjs_pkg::ID_W-1:0]          out_job_id,
  input logic [cjs_pkg::OUT_TIME_W-1:0]    out_finish,
  input logic [cjs_pkg::OUT_TIME_W-1:0]    out_first
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == cjs_pkg::ST_ACCEPTED || out_status == cjs_pkg::ST_DROPPED
      || out_status == cjs_pkg::ST_IDLE_TICK || out_status == cjs_pkg::ST_RUN_TICK
      || out_status == cjs_pkg::ST_DONE))
    else $error("result status out of range");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == cjs_pkg::ST_IDLE_TICK |->
      out_job_id == '0 && out_finish == '0 && out_first == '0)
    else $error("idle tick carries job data");

endmodule

bind cpu_job_scheduler_fcfs_sjf_rr_hrrn cjs_checker u_cjs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_job_id (out_ch.job_id_out),
  .out_finish (out_ch.finish_time),
  .out_first  (out_ch.first_start)
);
`default_nettype wire

>>> test/cjs_sched_checker.sv
// Checker of the job scheduler: predicts every result and compares it.
`timescale 1ns / 1ps
module cjs_sched_checker (
  input  logic      clk,
  input  logic      rst_n,
  cjs_in_if.sink    in_mon,
  cjs_out_if.sink   out_mon,
  input  logic      cfg_we,
  input  logic [cjs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cjs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int        fail_count,
  output int        results_owed,
  output int        jobs_done,
  output int        jobs_dropped,
  output logic      cpu_busy
);

  typedef struct {
    logic [7:0]  id;
    logic [7:0]  svc;
    logic [7:0]  used;
    logic [15:0] arr;
    logic [15:0] first;
    logic        started;
  } job_t;

  typedef struct packed {
    cjs_pkg::status_t status;
    logic [7:0]  id;
    logic [15:0] arr;
    logic [15:0] fin;
    logic [15:0] turn;
    logic [15:0] wait_t;
    logic [15:0] first;
  } sched_res_t;

  job_t        rq [0:16];
  int unsigned rq_n;
  logic [15:0] now;
  job_t        cur;
  logic        cur_valid;
  int unsigned slice;
  logic        held;
  logic [1:0]  policy;
  logic [7:0]  quantum;
  sched_res_t  owed_q [$];

  // True when job a wins over incumbent b under the current policy.
  function automatic logic wins(job_t a, job_t b);
    longint unsigned na, nb;
    if (policy == cjs_pkg::POL_SJF) return a.svc < b.svc;
    if (policy == cjs_pkg::POL_HRRN) begin
      na = longint'(16'(now - a.arr)) + a.svc;
      nb = longint'(16'(now - b.arr)) + b.svc;
      return na * b.svc > nb * a.svc;
    end
    return 1'b0;
  endfunction

  task automatic pick(input job_t cand [0:16], input int unsigned n);
    int unsigned best, k;
    best = 0;
    k = 0;
    for (int unsigned i = 1; i < n; i++)
      if (wins(cand[i], cand[best])) best = i;
    cur = cand[best];
    for (int unsigned i = 0; i < n; i++)
      if (i != best && k < 16) begin
        rq[k] = cand[i];
        k++;
      end
    rq_n = k;
    cur_valid = 1'b1;
    slice = 0;
    if (!cur.started) begin
      cur.started = 1'b1;
      cur.first = now;
    end
  endtask

  task automatic predict(input logic req, input logic [7:0] id, input logic [7:0] svc,
                         output sched_res_t r);
    job_t cand [0:16];
    r = '0;
    if (req == cjs_pkg::REQ_ARRIVAL) begin
      r.id = id;
      if (rq_n < 16) begin
        rq[rq_n] = '{id: id, svc: svc, used: 8'd0, arr: now, first: 16'd0, started: 1'b0};
        rq_n++;
        r.status = cjs_pkg::ST_ACCEPTED;
      end else begin
        r.status = cjs_pkg::ST_DROPPED;
        jobs_dropped++;
      end
      return;
    end
    for (int unsigned i = 0; i < 17; i++) cand[i] = rq[i];
    if (held) begin
      // preempted job joins as the last candidate
      cand[rq_n] = cur;
      held = 1'b0;
      cur_valid = 1'b0;
      pick(cand, rq_n + 1);
    end else if (!cur_valid && rq_n > 0) begin
      pick(cand, rq_n);
    end
    if (!cur_valid) begin
      now++;
      r.status = cjs_pkg::ST_IDLE_TICK;
      return;
    end
    cur.used++;
    now++;
    if (slice < 255) slice++;
    r.id = cur.id;
    if (cur.used >= cur.svc) begin
      r.status = cjs_pkg::ST_DONE;
      r.arr = cur.arr;
      r.fin = now;
      r.turn = now - cur.arr;
      r.wait_t = r.turn - cur.svc;
      r.first = cur.first;
      cur_valid = 1'b0;
      jobs_done++;
      return;
    end
    if (policy == cjs_pkg::POL_RR && slice >= quantum) held = 1'b1;
    r.status = cjs_pkg::ST_RUN_TICK;
  endtask

  always @(posedge clk) begin
    sched_res_t r, e;
    if (!rst_n) begin
      rq_n = 0;
      now = '0;
      cur_valid = 1'b0;
      slice = 0;
      held = 1'b0;
      policy = cjs_pkg::POL_FCFS;
      quantum = 8'd1;
      owed_q.delete();
      fail_count <= 0;
      jobs_done = 0;
      jobs_dropped = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == cjs_pkg::CFG_POLICY) policy = cfg_wdata[1:0];
        else quantum = cfg_wdata;
      end
      if (in_mon.valid && in_mon.ready) begin
        predict(in_mon.req_type, in_mon.job_id, in_mon.service_time, r);
        owed_q.push_back(r);
      end
      if (out_mon.valid && out_mon.ready) begin
        r = '{status: cjs_pkg::status_t'(out_mon.status), id: out_mon.job_id_out,
              arr: out_mon.arrival_stamp, fin: out_mon.finish_time,
              turn: out_mon.turnaround, wait_t: out_mon.waiting_time,
              first: out_mon.first_start};
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, r);
          fail_count <= fail_count + 1;
        end else begin
          e = owed_q.pop_front();
          if (r != e) begin
            $display({"%0t: mismatch expected st=%0d id=%0d arr=%0d fin=%0d",
                      " turn=%0d wait=%0d first=%0d"},
                     $time, e.status, e.id, e.arr, e.fin, e.turn, e.wait_t, e.first);
            $display({"%0t:            actual st=%0d id=%0d arr=%0d fin=%0d",
                      " turn=%0d wait=%0d first=%0d"},
                     $time, r.status, r.id, r.arr, r.fin, r.turn, r.wait_t, r.first);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    results_owed <= owed_q.size();
    cpu_busy <= cur_valid || held || rq_n != 0;
  end
endmodule

>>> test/cpu_job_scheduler_fcfs_sjf_rr_hrrn_tb.sv
// Top of the job scheduler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module cpu_job_scheduler_fcfs_sjf_rr_hrrn_tb;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [cjs_pkg::CFG_IDX_W-1:0]  cfg_index = cjs_pkg::CFG_POLICY;
  logic [cjs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  int   fail_count, results_owed, jobs_done, jobs_dropped;
  logic cpu_busy;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   items_sent = 0;
  int   cycles = 0;

  cjs_in_if  in_ch ();
  cjs_out_if out_ch ();

  cpu_job_scheduler_fcfs_sjf_rr_hrrn dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  cjs_sched_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .results_owed(results_owed), .jobs_done(jobs_done),
    .jobs_dropped(jobs_dropped), .cpu_busy(cpu_busy)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = cjs_pkg::REQ_TICK;
    in_ch.job_id = '0;
    in_ch.service_time = 8'd1;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(input logic req, input logic [7:0] id, input logic [7:0] svc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.job_id <= id;
    in_ch.service_time <= svc;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // hold until every owed result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // tick until the queue and the CPU are empty
  task automatic run_dry();
    drain();
    while (cpu_busy) begin
      send(cjs_pkg::REQ_TICK, 8'($urandom), 8'($urandom));
      drain();
    end
  endtask

  task automatic configure(input logic [1:0] pol, input logic [7:0] quant);
    cfg_we <= 1'b1;
    cfg_index <= cjs_pkg::CFG_POLICY;
    cfg_wdata <= {6'd0, pol};
    @(posedge clk);
    cfg_index <= cjs_pkg::CFG_QUANTUM;
    cfg_wdata <= quant;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_svc();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return 8'($urandom_range(6, 1));
    if (p < 96) return 8'($urandom_range(40, 7));
    if (p < 98) return 8'd128;
    return 8'd255;
  endfunction

  task automatic random_run(input int n);
    int k;
    k = 0;
    while (k < n) begin
      if ($urandom_range(99) < 3) begin
        // burst past the queue depth
        repeat (18) send(cjs_pkg::REQ_ARRIVAL, 8'($urandom), rand_svc());
        k += 18;
      end else if ($urandom_range(99) < 22) begin
        send(cjs_pkg::REQ_ARRIVAL, 8'($urandom), rand_svc());
        k++;
      end else begin
        send(cjs_pkg::REQ_TICK, 8'($urandom), 8'($urandom));
        k++;
      end
    end
  endtask

  task automatic regime(input int sidle, input int ridle);
    logic [7:0] quants [3];
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    quants = '{8'd1, 8'd255, 8'($urandom_range(8, 2))};
    for (int p = 0; p < 4; p++) begin
      drain();
      configure(2'(p), quants[$urandom_range(2)]);
      random_run(100);
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: id and service extremes, queue full, every policy, quantum ends
    configure(cjs_pkg::POL_FCFS, 8'd1);
    send(cjs_pkg::REQ_ARRIVAL, 8'd0, 8'd1);
    send(cjs_pkg::REQ_ARRIVAL, 8'd255, 8'd255);
    for (int i = 0; i < 15; i++) send(cjs_pkg::REQ_ARRIVAL, 8'(i + 1), 8'(i % 3 + 1));
    repeat (4) send(cjs_pkg::REQ_TICK, 8'd0, 8'd0);
    drain();
    configure(cjs_pkg::POL_SJF, 8'd255);
    repeat (2) send(cjs_pkg::REQ_TICK, 8'hff, 8'hff);
    drain();
    configure(cjs_pkg::POL_HRRN, 8'd1);
    repeat (2) send(cjs_pkg::REQ_TICK, 8'd0, 8'd0);
    drain();
    configure(cjs_pkg::POL_RR, 8'd1);
    run_dry();

    regime(22, 60);
    regime(60, 22);
    regime(0, 0);
    drain();
    repeat (200) @(posedge clk);

    $display("sent %0d items under all four policies; %0d jobs completed, %0d dropped",
             items_sent, jobs_done, jobs_dropped);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
